// ===== rtl/mfek_pkg.sv =====
package mfek_pkg;

  // Fixed field widths
  localparam int unsigned NODE_W  = 7;
  localparam int unsigned CAP_W   = 31;
  localparam int unsigned FLOW_W  = 32;
  localparam int unsigned TOTAL_W = 38;
  localparam int unsigned BN_W    = 27;
  localparam int unsigned RES_W   = 33;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;

  // Bottleneck seed at the source, limits one augmentation
  localparam logic [BN_W-1:0] SEED_LIMIT = BN_W'(100000000);

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd2;

  typedef logic [NODE_W-1:0] node_field_t;

endpackage

// ===== rtl/max_flow_bfs_augmenting_core.sv =====
// Edmonds-Karp maximum flow engine over a dense NODES x NODES capacity matrix held in
// on-chip memory. After reset the block sweeps both matrices to zero, one entry per
// cycle, with in_tready low; config writes are taken meanwhile. A load transaction
// (tuser=0) writes one edge capacity if both nodes are in range; loads stream at one
// per cycle while the block is idle. A run transaction (tuser=1) first clears the
// flow matrix; if source or sink is out of range or both are equal it returns a zero
// total, else it repeats breadth-first searches: each dequeued node's row is scanned
// up to highest_node, one matrix entry per cycle through the single read port, and
// each augmenting path does a read-modify-write on the flow memory per path edge.
// One augmentation moves at most 100000000 units. The run returns one transaction
// with the 38-bit total; loads give none. Loads are accepted while a result waits.
module max_flow_bfs_augmenting_core #(
  parameter int unsigned NODES = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mfek_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfek_pkg::NODE_W-1:0]        cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [6:0] from_node, [13:7] to_node, [44:14] capacity, rest zero
  input  logic [mfek_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] req_type
  input  logic                               in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [37:0] max_flow, rest zero
  output logic [mfek_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import mfek_pkg::*;

  localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [3:0] ST_RST_CLR = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_CLR     = 4'd2;
  localparam logic [3:0] ST_INIT    = 4'd3;
  localparam logic [3:0] ST_DEQ     = 4'd4;
  localparam logic [3:0] ST_DEQ_W   = 4'd5;
  localparam logic [3:0] ST_SCAN    = 4'd6;
  localparam logic [3:0] ST_AUG_P   = 4'd7;
  localparam logic [3:0] ST_AUG_R   = 4'd8;
  localparam logic [3:0] ST_AUG_W1  = 4'd9;
  localparam logic [3:0] ST_AUG_W2  = 4'd10;
  localparam logic [3:0] ST_FIN     = 4'd11;

  // Memories
  logic [CAP_W-1:0]  cap_mem  [DEPTH];
  logic [FLOW_W-1:0] flow_mem [DEPTH];
  logic [BN_W-1:0]   bn_mem   [NODES];
  logic [NW-1:0]     par_mem  [NODES];
  logic [NW-1:0]     q_mem    [NODES];

  // Registers
  logic [3:0]          state_r, state_nxt;
  node_field_t         src_cfg_r, snk_cfg_r, hi_cfg_r;
  logic [NW-1:0]       s_r, t_r, top_r;
  logic                bad_r;
  logic [AW:0]         clr_r, clr_nxt;
  logic [NODES-1:0]    reached_r, reached_nxt;
  logic [NW:0]         q_head_r, q_head_nxt, q_tail_r, q_tail_nxt;
  logic [NW-1:0]       u_r, u_nxt;
  logic [NW-1:0]       iss_v_r, iss_v_nxt, dv_r, dv_nxt;
  logic                iss_done_r, iss_done_nxt, dval_r, dval_nxt;
  logic [BN_W-1:0]     b_r, b_nxt;
  logic [NW-1:0]       au_r, au_nxt, p_r, p_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_data_r, out_data_nxt;

  // Read data
  logic [CAP_W-1:0]  cap_rd;
  logic [FLOW_W-1:0] flow_rd;
  logic [BN_W-1:0]   bn_rd;
  logic [NW-1:0]     par_rd, q_rd;

  // Memory controls
  logic              cap_we, flow_we, bn_we, par_we, q_we;
  logic [AW-1:0]     cap_wa, flow_wa, mat_ra;
  logic [CAP_W-1:0]  cap_wd;
  logic [FLOW_W-1:0] flow_wd;
  logic              mat_re, bn_re, par_re, q_re;
  logic [NW-1:0]     bn_wa, bn_ra, par_wa, par_ra, q_wa, q_ra;
  logic [BN_W-1:0]   bn_wd;
  logic [NW-1:0]     par_wd, q_wd;

  // Input decode
  logic              in_fire, load_ok;
  node_field_t       in_from, in_to;
  logic [CAP_W-1:0]  in_cap;
  logic [NW-1:0]     top_eff;

  // Scan datapath
  logic signed [RES_W-1:0] res;
  logic                    take;
  logic [BN_W-1:0]         bn_new;

  assign in_from = in_tdata[NODE_W-1:0];
  assign in_to   = in_tdata[2*NODE_W-1:NODE_W];
  assign in_cap  = in_tdata[2*NODE_W+CAP_W-1:2*NODE_W];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign load_ok    = (32'(in_from) < NODES) && (32'(in_to) < NODES);
  assign top_eff    = (32'(hi_cfg_r) >= NODES) ? NW'(NODES - 1) : NW'(hi_cfg_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-TOTAL_W){1'b0}}, out_data_r};

  // Residual and bottleneck of the entry under scan
  assign res    = $signed({2'b00, cap_rd}) - $signed({flow_rd[FLOW_W-1], flow_rd});
  assign take   = dval_r && !reached_r[dv_r] && (res > 0);
  assign bn_new = (res > $signed({{(RES_W-BN_W){1'b0}}, bn_rd})) ? bn_rd : res[BN_W-1:0];

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cfg_r <= '0;
      snk_cfg_r <= NODE_W'(127);
      hi_cfg_r  <= NODE_W'(127);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOURCE:  src_cfg_r <= cfg_data;
        CFG_SINK:    snk_cfg_r <= cfg_data;
        CFG_HIGHEST: hi_cfg_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    reached_nxt   = reached_r;
    q_head_nxt    = q_head_r;
    q_tail_nxt    = q_tail_r;
    u_nxt         = u_r;
    iss_v_nxt     = iss_v_r;
    iss_done_nxt  = iss_done_r;
    dv_nxt        = dv_r;
    dval_nxt      = 1'b0;
    b_nxt         = b_r;
    au_nxt        = au_r;
    p_nxt         = p_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    cap_we  = 1'b0;
    cap_wa  = {NW'(in_from), NW'(in_to)};
    cap_wd  = in_cap;
    flow_we = 1'b0;
    flow_wa = clr_r[AW-1:0];
    flow_wd = '0;
    mat_re  = 1'b0;
    mat_ra  = {u_r, iss_v_r};
    bn_we   = 1'b0;
    bn_wa   = dv_r;
    bn_wd   = bn_new;
    bn_re   = 1'b0;
    bn_ra   = q_rd;
    par_we  = 1'b0;
    par_wa  = dv_r;
    par_wd  = u_r;
    par_re  = 1'b0;
    par_ra  = au_r;
    q_we    = 1'b0;
    q_wa    = q_tail_r[NW-1:0];
    q_wd    = dv_r;
    q_re    = 1'b0;
    q_ra    = q_head_r[NW-1:0];

    case (state_r)
      ST_RST_CLR: begin
        cap_we  = 1'b1;
        cap_wa  = clr_r[AW-1:0];
        cap_wd  = '0;
        flow_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AW-1:0] == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_tuser == REQ_LOAD) begin
          cap_we = load_ok;
        end else if (in_fire) begin
          total_nxt = '0;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        flow_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AW-1:0] == AW'(DEPTH - 1)) begin
          state_nxt = bad_r ? ST_FIN : ST_INIT;
        end
      end
      ST_INIT: begin
        reached_nxt       = '0;
        reached_nxt[s_r]  = 1'b1;
        bn_we             = 1'b1;
        bn_wa             = s_r;
        bn_wd             = SEED_LIMIT;
        q_we              = 1'b1;
        q_wa              = '0;
        q_wd              = s_r;
        q_head_nxt        = '0;
        q_tail_nxt        = (NW+1)'(1);
        state_nxt         = ST_DEQ;
      end
      ST_DEQ: begin
        if (q_head_r == q_tail_r) begin
          state_nxt = ST_FIN;
        end else begin
          q_re       = 1'b1;
          q_head_nxt = q_head_r + 1'b1;
          state_nxt  = ST_DEQ_W;
        end
      end
      ST_DEQ_W: begin
        u_nxt        = q_rd;
        bn_re        = 1'b1;
        iss_v_nxt    = '0;
        iss_done_nxt = 1'b0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        // issue one matrix read per cycle
        if (!iss_done_r) begin
          mat_re   = 1'b1;
          dv_nxt   = iss_v_r;
          dval_nxt = 1'b1;
          if (iss_v_r == top_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_v_nxt = iss_v_r + 1'b1;
          end
        end
        // evaluate the entry read last cycle
        if (take) begin
          reached_nxt[dv_r] = 1'b1;
          par_we = 1'b1;
          bn_we  = 1'b1;
          if (q_tail_r < (NW+1)'(NODES)) begin
            q_we       = 1'b1;
            q_tail_nxt = q_tail_r + 1'b1;
          end
        end
        if (take && dv_r == t_r) begin
          b_nxt     = bn_new;
          au_nxt    = t_r;
          dval_nxt  = 1'b0;
          state_nxt = ST_AUG_P;
        end else if (dval_r && dv_r == top_r) begin
          dval_nxt  = 1'b0;
          state_nxt = ST_DEQ;
        end
      end
      ST_AUG_P: begin
        if (au_r == s_r) begin
          total_nxt = total_r + TOTAL_W'(b_r);
          state_nxt = ST_INIT;
        end else begin
          par_re    = 1'b1;
          state_nxt = ST_AUG_R;
        end
      end
      ST_AUG_R: begin
        p_nxt     = par_rd;
        mat_re    = 1'b1;
        mat_ra    = {par_rd, au_r};
        state_nxt = ST_AUG_W1;
      end
      ST_AUG_W1: begin
        flow_we   = 1'b1;
        flow_wa   = {p_r, au_r};
        flow_wd   = flow_rd + FLOW_W'(b_r);
        mat_re    = 1'b1;
        mat_ra    = {au_r, p_r};
        state_nxt = ST_AUG_W2;
      end
      ST_AUG_W2: begin
        flow_we   = 1'b1;
        flow_wa   = {au_r, p_r};
        flow_wd   = flow_rd - FLOW_W'(b_r);
        au_nxt    = p_r;
        state_nxt = ST_AUG_P;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = total_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RST_CLR;
      clr_r       <= '0;
      reached_r   <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      iss_done_r  <= 1'b0;
      dval_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      reached_r   <= reached_nxt;
      q_head_r    <= q_head_nxt;
      q_tail_r    <= q_tail_nxt;
      iss_done_r  <= iss_done_nxt;
      dval_r      <= dval_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Run parameters, latched at run start
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && in_tuser == REQ_RUN) begin
      s_r   <= NW'(src_cfg_r);
      t_r   <= NW'(snk_cfg_r);
      top_r <= top_eff;
      bad_r <= (32'(src_cfg_r) >= NODES) || (32'(snk_cfg_r) >= NODES) ||
               (src_cfg_r == snk_cfg_r);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    iss_v_r    <= iss_v_nxt;
    dv_r       <= dv_nxt;
    b_r        <= b_nxt;
    au_r       <= au_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
  end

  // Capacity and flow matrices, shared read address
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_wa] <= cap_wd;
    end
    if (mat_re) begin
      cap_rd <= cap_mem[mat_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
    if (mat_re) begin
      flow_rd <= flow_mem[mat_ra];
    end
  end

  // Per-node bottleneck, parent and search queue
  always_ff @(posedge clk) begin
    if (bn_we) begin
      bn_mem[bn_wa] <= bn_wd;
    end
    if (bn_re) begin
      bn_rd <= bn_mem[bn_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (par_re) begin
      par_rd <= par_mem[par_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd <= q_mem[q_ra];
    end
  end

  // Checks
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    q_head_r <= q_tail_r)
    else $error("queue head passed tail");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_tail_r <= (NW+1)'(NODES))
    else $error("queue overflow");

  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_AUG_P && state_r != ST_IDLE) |=> $stable(total_r))
    else $error("flow total changed outside augmentation");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RST_CLR || state_r == ST_SCAN) |-> !in_tready)
    else $error("input accepted while busy");

endmodule

// ===== test/tb_max_flow_bfs_augmenting_core.sv =====
module tb_max_flow_bfs_augmenting_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mfek_pkg::*;

  localparam int unsigned NODES      = 128;
  localparam int unsigned NODE_SQ    = NODES * NODES;
  localparam longint      CYCLE_CAP  = 30_000_000;
  localparam int unsigned HOLD_LEN   = 30_000;
  localparam int unsigned HOLD_AFTER = 10;
  localparam int unsigned DRAIN_WAIT = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_MASK = '1;

  typedef enum logic [1:0] {ROW_LOAD, ROW_RUN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [6:0]         from_n;
    logic [6:0]         to_n;
    logic [30:0]        cap;
    logic [CFG_IDX_W-1:0] idx;
    bit                 typed;
    logic [TOTAL_W-1:0] total;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NODE_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  int unsigned cap_mem [NODE_SQ];
  longint      flow_mem [NODE_SQ];
  int unsigned src_reg;
  int unsigned sink_reg;
  int unsigned top_reg;

  logic [TOTAL_W-1:0] flow_totals_q [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned totals_seen;
  longint      cycles;
  bit          hold_done;

  max_flow_bfs_augmenting_core #(.NODES(NODES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Edmonds-Karp on the shadow matrices with the current register values
  function automatic logic [TOTAL_W-1:0] compute_max_flow();
    longint      bneck [NODES];
    int unsigned pred [NODES];
    int unsigned queue_n [NODES];
    bit          seen [NODES];
    int unsigned head, tail, u, v, s, t, top;
    longint      r, b;
    logic [TOTAL_W-1:0] total;
    total = '0;
    s = src_reg;
    t = sink_reg;
    top = (top_reg > NODES - 1) ? NODES - 1 : top_reg;
    foreach (flow_mem[k]) flow_mem[k] = 0;
    if (s == t) return '0;
    forever begin
      foreach (seen[k]) begin
        seen[k] = 1'b0;
        bneck[k] = 0;
      end
      head = 0;
      tail = 0;
      b = 0;
      seen[s] = 1'b1;
      bneck[s] = 100000000;
      queue_n[tail++] = s;
      while (head < tail && b == 0) begin
        u = queue_n[head++];
        for (v = 0; v <= top; v++) begin
          if (seen[v]) continue;
          r = longint'(cap_mem[u * NODES + v]) - flow_mem[u * NODES + v];
          if (r <= 0) continue;
          seen[v] = 1'b1;
          pred[v] = u;
          bneck[v] = (bneck[u] < r) ? bneck[u] : r;
          if (tail < NODES) queue_n[tail++] = v;
          if (v == t) begin
            b = bneck[t];
            break;
          end
        end
      end
      if (b <= 0) break;
      // push the bottleneck along the path, skew-symmetric
      v = t;
      while (v != s) begin
        u = pred[v];
        flow_mem[u * NODES + v] += b;
        flow_mem[v * NODES + u] -= b;
        v = u;
      end
      total = (total + TOTAL_W'(b)) & TOTAL_MASK;
    end
    return total;
  endfunction

  task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got,
                                 logic [TOTAL_W-1:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Wait until every run has reported, then let trailing loads finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (flow_totals_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NODE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SOURCE:  src_reg = 32'(val);
      CFG_SINK:    sink_reg = 32'(val);
      CFG_HIGHEST: top_reg = 32'(val);
      default: ;
    endcase
  endtask

  // One input transaction; leaves tvalid high for back-to-back items
  task automatic send_req(logic kind, logic [6:0] f, logic [6:0] t, logic [30:0] c,
                          bit typed, logic [TOTAL_W-1:0] total);
    logic [TOTAL_W-1:0] predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, c, t, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (kind == REQ_LOAD) begin
      cap_mem[f * NODES + t] = 32'(c);
    end else begin
      predicted = compute_max_flow();
      flow_totals_q.push_back(typed ? total : predicted);
    end
  endtask

  // Result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      totals_seen++;
      if (flow_totals_q.size() == 0) begin
        report_mismatch("unexpected max_flow", out_tdata[TOTAL_W-1:0], '0);
      end else begin
        if (out_tdata[TOTAL_W-1:0] != flow_totals_q[0])
          report_mismatch("max_flow", out_tdata[TOTAL_W-1:0], flow_totals_q[0]);
        void'(flow_totals_q.pop_front());
      end
    end
  end

  // Receiver backpressure, with one long hold during random traffic to fill the block up
  initial begin
    out_tready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && totals_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) < 75);
      @(posedge clk);
    end
  end

  // Run time limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows [$];
    stim_row_t   row;
    int unsigned gap, top, n, r;
    bit          busy_phase;
    logic        kind;
    logic [6:0]  f, t;
    logic [30:0] c;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    errors = 0;
    items_sent = 0;
    totals_seen = 0;
    cycles = 0;
    foreach (cap_mem[k]) cap_mem[k] = 0;
    src_reg = 0;
    sink_reg = 127;
    top_reg = 127;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: kind, from, to, cap, cfg index, typed, total
    rows = '{
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b1, 38'd0},
      '{ROW_LOAD, 7'd0,   7'd127, 31'h7FFF_FFFF,  CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b1, 38'd2147483647},
      '{ROW_LOAD, 7'd5,   7'd5,   31'd99,         CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_LOAD, 7'd127, 7'd127, 31'h7FFF_FFFF,  CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_CFG,  7'd0,   7'd0,   31'd0,          CFG_SINK,    1'b0, 38'd0},
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b1, 38'd0},
      '{ROW_CFG,  7'd127, 7'd0,   31'd0,          CFG_SINK,    1'b0, 38'd0},
      '{ROW_CFG,  7'd1,   7'd0,   31'd0,          CFG_HIGHEST, 1'b0, 38'd0},
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b1, 38'd0},
      '{ROW_CFG,  7'd127, 7'd0,   31'd0,          CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_CFG,  7'd1,   7'd0,   31'd0,          CFG_SINK,    1'b0, 38'd0},
      '{ROW_LOAD, 7'd127, 7'd1,   31'd3,          CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b1, 38'd3},
      '{ROW_CFG,  7'd5,   7'd0,   31'd0,          CFG_SPARE,   1'b0, 38'd0},
      '{ROW_CFG,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_CFG,  7'd127, 7'd0,   31'd0,          CFG_HIGHEST, 1'b0, 38'd0},
      '{ROW_LOAD, 7'd0,   7'd1,   31'd0,          CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_LOAD, 7'd0,   7'd1,   31'd10,         CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_LOAD, 7'd0,   7'd1,   31'd4,          CFG_SOURCE,  1'b0, 38'd0},
      '{ROW_RUN,  7'd0,   7'd0,   31'd0,          CFG_SOURCE,  1'b0, 38'd0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.idx, row.from_n);
      end else begin
        send_req(row.kind == ROW_RUN, row.from_n, row.to_n, row.cap,
                 row.typed, row.total);
      end
    end

    // random phases: small windows keep the searches short
    while (items_sent < 1200) begin
      wait_idle();
      r = $urandom_range(9);
      top = (r == 0) ? 1 : $urandom_range(15, 2);
      write_reg(CFG_HIGHEST, NODE_W'(top));
      write_reg(CFG_SOURCE, NODE_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                              : $urandom_range(top)));
      write_reg(CFG_SINK, NODE_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                            : $urandom_range(top)));
      if ($urandom_range(3) == 0) write_reg(CFG_SPARE, NODE_W'($urandom_range(127)));
      busy_phase = ($urandom_range(3) == 0);
      n = $urandom_range(120, 60);
      for (int i = 0; i < n; i++) begin
        gap = busy_phase ? 0 : pick_gap();
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        kind = ($urandom_range(29) == 0) ? REQ_RUN : REQ_LOAD;
        if ($urandom_range(19) == 0) begin
          f = 7'($urandom_range(127));
          t = 7'($urandom_range(127));
        end else begin
          f = 7'($urandom_range(top));
          t = 7'($urandom_range(top));
        end
        r = $urandom_range(99);
        if (r < 10)      c = '0;
        else if (r < 13) c = 31'($urandom());
        else             c = 31'($urandom_range(1000, 1));
        send_req(kind, f, t, c, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    // drain
    while (flow_totals_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== max_flow_bfs_augmenting_core.f =====
rtl/mfek_pkg.sv
rtl/max_flow_bfs_augmenting_core.sv
test/tb_max_flow_bfs_augmenting_core.sv
